>>> src/b58e_pkg.sv
`default_nettype none

package b58e_pkg;

    localparam int MAX_BYTES   = 34;
    localparam int STORE_DEPTH = 47;
    localparam int MAX_CHARS   = 47;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    localparam int RADIX       = 58;
    localparam int RECIP_SHIFT = 20;
    localparam logic [14:0] RECIP_58 = 15'((2 ** RECIP_SHIFT + RADIX - 1) / RADIX);

    localparam logic [6:0] CHAR_ONE = 7'h31;

    localparam logic [8*58-1:0] B58_ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
        logic       error;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_EMIT_ZERO,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_ERR
    } state_t;

    function automatic logic [6:0] b58_char(input logic [5:0] digit);
        logic [7:0] code;
        code = 8'd0;
        if (digit < 6'(RADIX))
        begin
            code = B58_ALPHABET[8 * (RADIX - 1 - int'(digit)) +: 8];
        end
        return code[6:0];
    endfunction

endpackage

`default_nettype wire

>>> src/b58e_divmod.sv
`default_nettype none

module b58e_divmod (
    input  logic [7:0] carry_in,
    input  logic [5:0] digit_in,
    output logic [7:0] carry_out,
    output logic [5:0] digit_out
);
    import b58e_pkg::*;

    logic [13:0] acc;
    logic [28:0] prod;
    logic [7:0]  quot;
    logic [13:0] back;
    logic [13:0] diff;

    // The reciprocal is exact for every value below 256 * 58 + 256.
    always_comb
    begin
        acc       = {digit_in, 8'd0} + {6'd0, carry_in};
        prod      = {15'd0, acc} * {14'd0, RECIP_58};
        quot      = prod[RECIP_SHIFT +: 8];
        back      = {quot, 6'd0} - {4'd0, quot, 2'd0} - {5'd0, quot, 1'd0};
        diff      = acc - back;
        carry_out = quot;
        digit_out = diff[5:0];
    end

endmodule

`default_nettype wire

>>> src/base58_encoder_core.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// byte      in         byte_valid/byte_stall   b58e_pkg::in_t  (data_byte, last_byte)
// char      out        char_valid/char_stall   b58e_pkg::out_t (char_code, last_char, error)
//
// Each accepted byte is folded into the digit store by carry passes through the shared
// divide-by-58 unit, one digit per pass, until all digits are passed and the carry is zero.
// On the final byte, each leading '1' is loaded from ST_EMIT_ZERO, and each digit is first
// read through the single digit store read port in ST_EMIT_RD, then loaded in ST_EMIT_LD.
// Reset clears all control state; the digit store is not cleared.
// A stalled char output holds its register and pauses emission.

module base58_encoder_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_stall,
    input  b58e_pkg::in_t  byte_data,
    output logic           char_valid,
    input  logic           char_stall,
    output b58e_pkg::out_t char_data
);
    import b58e_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   byte_count_reg, byte_count_next;
    logic [CNT_W-1:0]   zero_count_reg, zero_count_next;
    logic               lead_zero_reg, lead_zero_next;
    logic [CNT_W-1:0]   digit_count_reg, digit_count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [7:0]         carry_reg, carry_next;
    logic               last_reg, last_next;
    logic [CNT_W-1:0]   emit_count_reg, emit_count_next;
    logic               char_valid_reg, char_valid_next;
    out_t               char_data_reg, char_data_next;

    logic [5:0]         mem [STORE_DEPTH];
    logic [5:0]         rd_data_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;

    logic [5:0]         dm_digit_in;
    logic [7:0]         dm_carry_out;
    logic [5:0]         dm_digit_out;

    logic               char_free;
    logic               fold_more;
    logic               load;
    out_t               load_data;
    logic               clear_run;
    logic               last_c;

    b58e_divmod u_divmod (
        .carry_in  (carry_reg),
        .digit_in  (dm_digit_in),
        .carry_out (dm_carry_out),
        .digit_out (dm_digit_out)
    );

    assign dm_digit_in = (idx_reg < digit_count_reg) ? rd_data_reg : 6'd0;
    assign char_free   = !char_valid_reg || !char_stall;
    assign fold_more   = (idx_reg < CNT_W'(STORE_DEPTH)) &&
                         ((idx_reg < digit_count_reg) || (carry_reg != 8'd0));

    always_comb
    begin
        state_next       = state_reg;
        byte_count_next  = byte_count_reg;
        zero_count_next  = zero_count_reg;
        lead_zero_next   = lead_zero_reg;
        digit_count_next = digit_count_reg;
        idx_next         = idx_reg;
        carry_next       = carry_reg;
        last_next        = last_reg;
        emit_count_next  = emit_count_reg;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        load             = 1'b0;
        load_data        = '0;
        clear_run        = 1'b0;
        last_c           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (byte_valid)
                begin
                    last_next = byte_data.last_byte;
                    if (byte_count_reg < CNT_W'(MAX_BYTES))
                    begin
                        byte_count_next = byte_count_reg + 1'b1;
                        if (lead_zero_reg && (byte_data.data_byte == 8'd0))
                        begin
                            zero_count_next = zero_count_reg + 1'b1;
                        end
                        else
                        begin
                            lead_zero_next = 1'b0;
                        end
                        carry_next = byte_data.data_byte;
                        idx_next   = '0;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_FOLD;
                    end
                    else
                    begin
                        byte_count_next = CNT_W'(MAX_BYTES + 1);
                        if (byte_data.last_byte)
                        begin
                            state_next = ST_ERR;
                        end
                    end
                end
            end
            ST_FOLD:
            begin
                if (fold_more)
                begin
                    wr_en      = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    carry_next = dm_carry_out;
                    if (idx_reg >= digit_count_reg)
                    begin
                        digit_count_next = idx_reg + 1'b1;
                    end
                    if (idx_reg < CNT_W'(STORE_DEPTH - 1))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = ADDR_W'(idx_reg + 1'b1);
                    end
                end
                else if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (zero_count_reg != '0)
                begin
                    state_next = ST_EMIT_ZERO;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_ZERO:
            begin
                if (char_free)
                begin
                    last_c = (emit_count_reg == CNT_W'(MAX_CHARS - 1)) ||
                             ((zero_count_reg == CNT_W'(1)) && (digit_count_reg == '0));
                    load                = 1'b1;
                    load_data.char_code = CHAR_ONE;
                    load_data.last_char = last_c;
                    load_data.error     = 1'b0;
                    emit_count_next     = emit_count_reg + 1'b1;
                    zero_count_next     = zero_count_reg - 1'b1;
                    if (last_c)
                    begin
                        clear_run  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (zero_count_reg == CNT_W'(1))
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ADDR_W'(digit_count_reg - 1'b1);
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (char_free)
                begin
                    last_c = (emit_count_reg == CNT_W'(MAX_CHARS - 1)) ||
                             (digit_count_reg == CNT_W'(1));
                    load                = 1'b1;
                    load_data.char_code = b58_char(rd_data_reg);
                    load_data.last_char = last_c;
                    load_data.error     = 1'b0;
                    emit_count_next     = emit_count_reg + 1'b1;
                    digit_count_next    = digit_count_reg - 1'b1;
                    if (last_c)
                    begin
                        clear_run  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_ERR:
            begin
                if (char_free)
                begin
                    load                = 1'b1;
                    load_data.char_code = '0;
                    load_data.last_char = 1'b1;
                    load_data.error     = 1'b1;
                    clear_run           = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (clear_run)
        begin
            byte_count_next  = '0;
            zero_count_next  = '0;
            lead_zero_next   = 1'b1;
            digit_count_next = '0;
            emit_count_next  = '0;
        end

        char_data_next  = char_data_reg;
        char_valid_next = char_valid_reg;
        if (load)
        begin
            char_valid_next = 1'b1;
            char_data_next  = load_data;
        end
        else if (!char_stall)
        begin
            char_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            byte_count_reg  <= '0;
            zero_count_reg  <= '0;
            lead_zero_reg   <= 1'b1;
            digit_count_reg <= '0;
            idx_reg         <= '0;
            carry_reg       <= '0;
            last_reg        <= 1'b0;
            emit_count_reg  <= '0;
            char_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            byte_count_reg  <= byte_count_next;
            zero_count_reg  <= zero_count_next;
            lead_zero_reg   <= lead_zero_next;
            digit_count_reg <= digit_count_next;
            idx_reg         <= idx_next;
            carry_reg       <= carry_next;
            last_reg        <= last_next;
            emit_count_reg  <= emit_count_next;
            char_valid_reg  <= char_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_data_reg <= char_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ADDR_W'(idx_reg)] <= dm_digit_out;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign byte_stall = (state_reg != ST_IDLE);
    assign char_valid = char_valid_reg;
    assign char_data  = char_data_reg;

    // An error transaction always closes the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_data.error) |-> char_data.last_char)
        else $error("error transaction without last_char");

    // The stored digit count never exceeds the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= CNT_W'(STORE_DEPTH))
        else $error("digit count beyond store depth");

    // Folding only happens for bytes within the length limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD) |-> (byte_count_reg <= CNT_W'(MAX_BYTES)))
        else $error("fold pass on an over-length string");

    // After the final character is loaded the run state is back at its start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && load_data.last_char) |=>
            ((digit_count_reg == '0) && (zero_count_reg == '0) && lead_zero_reg))
        else $error("run state not cleared after final character");

endmodule

`default_nettype wire

>>> bench/b58e_checker.sv
`timescale 1ns / 100ps

module b58e_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    input  logic           byte_stall,
    input  b58e_pkg::in_t  byte_data,
    input  logic           char_valid,
    input  logic           char_stall,
    input  b58e_pkg::out_t char_data,
    output int             fail_count,
    output int             pending
);
    import b58e_pkg::*;

    logic [5:0] digits [STORE_DEPTH];
    int         digit_total;
    int         zero_total;
    int         byte_total;
    bit         leading;
    out_t       expected_chars[$];
    int         errors = 0;

    assign fail_count = errors;

    function automatic logic [6:0] ascii_of_digit(input logic [5:0] d);
        string alphabet;
        byte   c;
        alphabet = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
        c = alphabet.getc(int'(d));
        return c[6:0];
    endfunction

    task automatic clear_string();
        for (int k = 0; k < STORE_DEPTH; k++)
        begin
            digits[k] = '0;
        end
        digit_total = 0;
        zero_total  = 0;
        byte_total  = 0;
        leading     = 1'b1;
    endtask

    task automatic multiply_add(input logic [7:0] b);
        int carry;
        int j;
        int v;
        carry = int'(b);
        j = 0;
        while ((j < digit_total || carry != 0) && j < STORE_DEPTH)
        begin
            v = carry + 256 * ((j < digit_total) ? int'(digits[j]) : 0);
            digits[j] = 6'(v % 58);
            carry = v / 58;
            j++;
            if (j > digit_total)
            begin
                digit_total = j;
            end
        end
    endtask

    task automatic absorb_byte(input in_t t);
        out_t r;
        int   total;
        if (byte_total < MAX_BYTES)
        begin
            byte_total++;
            if (leading && t.data_byte == 8'h00)
            begin
                zero_total++;
            end
            else
            begin
                leading = 1'b0;
            end
            multiply_add(t.data_byte);
        end
        else
        begin
            byte_total = MAX_BYTES + 1;
        end
        if (t.last_byte)
        begin
            if (byte_total > MAX_BYTES)
            begin
                r.char_code = 7'd0;
                r.last_char = 1'b1;
                r.error     = 1'b1;
                expected_chars.push_back(r);
            end
            else
            begin
                total = zero_total + digit_total;
                if (total > MAX_CHARS)
                begin
                    total = MAX_CHARS;
                end
                for (int k = 0; k < total; k++)
                begin
                    if (k < zero_total)
                    begin
                        r.char_code = CHAR_ONE;
                    end
                    else
                    begin
                        r.char_code = ascii_of_digit(digits[digit_total - 1 - (k - zero_total)]);
                    end
                    r.last_char = (k == total - 1);
                    r.error     = 1'b0;
                    expected_chars.push_back(r);
                end
            end
            clear_string();
        end
    endtask

    task automatic check_char(input out_t got);
        out_t want;
        if (expected_chars.size() == 0)
        begin
            $error("char transaction with none expected: char_code %0d last_char %0b error %0b",
                   got.char_code, got.last_char, got.error);
            errors++;
        end
        else
        begin
            want = expected_chars.pop_front();
            if (got.char_code !== want.char_code)
            begin
                $error("char_code expected %0d actual %0d", want.char_code, got.char_code);
                errors++;
            end
            if (got.last_char !== want.last_char)
            begin
                $error("last_char expected %0b actual %0b", want.last_char, got.last_char);
                errors++;
            end
            if (got.error !== want.error)
            begin
                $error("error expected %0b actual %0b", want.error, got.error);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_string();
            expected_chars.delete();
            pending <= 0;
        end
        else
        begin
            if (char_valid && !char_stall)
            begin
                check_char(char_data);
            end
            if (byte_valid && !byte_stall)
            begin
                absorb_byte(byte_data);
            end
            pending <= expected_chars.size();
        end
    end

endmodule

>>> bench/tb_base58_encoder_core.sv
`timescale 1ns / 100ps

module tb_base58_encoder_core;
    import b58e_pkg::*;

    logic clk;
    logic rst_n;
    logic byte_valid;
    logic byte_stall;
    in_t  byte_data;
    logic char_valid;
    logic char_stall;
    out_t char_data;
    int   fail_count;
    int   pending;
    bit   calm;
    int   items;

    base58_encoder_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

    b58e_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        char_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 34);
    end

    task automatic send_byte(input logic [7:0] b, input logic lst);
        while (!calm && $urandom_range(0, 99) < 34)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid          <= 1'b1;
        byte_data.data_byte <= b;
        byte_data.last_byte <= lst;
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
        items++;
    endtask

    task automatic drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_string(input int len, input int zeros, input bit ones_only);
        logic [7:0] b;
        for (int k = 0; k < len; k++)
        begin
            if (k < zeros)
            begin
                b = 8'h00;
            end
            else if (ones_only)
            begin
                b = 8'hFF;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: b = 8'h00;
                    1: b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
            end
            send_byte(b, k == len - 1);
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int pick;
        int len;
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_data  <= '0;
        calm       = 1'b0;
        items      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h39, 1'b1);
        send_byte(8'h3A, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        drain();

        while (items < 300)
        begin
            calm = (items >= 100 && items < 160);
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                len = $urandom_range(1, 8);
                send_string(len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : 0,
                            1'b0);
            end
            else if (pick < 85)
            begin
                len = $urandom_range(28, MAX_BYTES);
                send_string(len, $urandom_range(0, 2), $urandom_range(0, 2) == 0);
            end
            else if (pick < 90)
            begin
                send_string(MAX_BYTES, 0, 1'b1);
            end
            else
            begin
                len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 6);
                send_string(len, $urandom_range(0, 2), 1'b0);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                drain();
            end
        end

        calm = 1'b0;
        drain();
        repeat (120) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
src/b58e_pkg.sv
src/b58e_divmod.sv
src/base58_encoder_core.sv
bench/b58e_checker.sv
bench/tb_base58_encoder_core.sv
